>>> hdl/sbfcd_pkg.sv
// ----------------------------------------------------------------------------
// sbfcd_pkg: shared types and constants of the SBUS frame channel decoder
// Frame layout, register indexes, mapping kinds and sequencer states.
// ----------------------------------------------------------------------------
package sbfcd_pkg;

  localparam int FRAME_BYTES   = 25;
  localparam int CHANNEL_COUNT = 16;
  localparam int RAW_W         = 11;
  localparam int MAP_W         = 12;
  localparam int POS_W         = 5;
  localparam int CH_W          = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int TOL_W         = 10;
  // channel payload runs from byte 1 through byte 22
  localparam int PAYLOAD_BITS  = CHANNEL_COUNT * RAW_W;
  localparam int LAST_PAYLOAD  = PAYLOAD_BITS / 8;

  localparam logic [7:0] HEAD_BYTE = 8'h0F;
  localparam logic [7:0] TAIL_BYTE = 8'h00;

  localparam logic [RAW_W-1:0] RANGE_MIN_RST = 11'd353;
  localparam logic [RAW_W-1:0] RANGE_MAX_RST = 11'd1695;
  localparam logic [RAW_W-1:0] MIDDLE_RST    = 11'd1024;
  localparam logic [TOL_W-1:0] TOL_RST       = 10'd100;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd3;

  typedef enum logic [1:0] {
    KIND_LINEAR = 2'd0,
    KIND_THREE  = 2'd1,
    KIND_TWO    = 2'd2,
    KIND_RAW    = 2'd3
  } map_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_LOAD = 2'd1,
    ST_DIV  = 2'd2,
    ST_SEND = 2'd3
  } seq_state_t;

  typedef struct packed {
    logic [11:0] quot;
    logic        rem_nz;
  } div_res_t;

  function automatic map_kind_t chan_kind(input logic [CH_W-1:0] ch);
    map_kind_t k;
    unique case (ch)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd8, 4'd9: k = KIND_LINEAR;
      4'd4, 4'd5:                         k = KIND_THREE;
      4'd6, 4'd7:                         k = KIND_TWO;
      default:                            k = KIND_RAW;
    endcase
    return k;
  endfunction

endpackage

>>> hdl/sbfcd_div.sv
// ----------------------------------------------------------------------------
// sbfcd_div: iterative restoring divider
// Computes floor(t * 2048 / d) for t <= d, one quotient bit per cycle through
// a single shared subtract and compare.
// ----------------------------------------------------------------------------
module sbfcd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [sbfcd_pkg::RAW_W-1:0]   dividend,
  input  logic [sbfcd_pkg::RAW_W-1:0]   divisor,
  output logic                          done,
  output sbfcd_pkg::div_res_t           res
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [3:0]                  cnt_r, cnt_nxt;
  logic [sbfcd_pkg::RAW_W-1:0] rem_r, rem_nxt;
  logic [sbfcd_pkg::RAW_W-1:0] d_r, d_nxt;
  logic [11:0]                 q_r, q_nxt;
  logic [11:0]                 op;
  logic [sbfcd_pkg::RAW_W-1:0] d_sel;
  logic [12:0]                 diff;
  logic                        ge;

  // shared step: compare the partial remainder against the divisor
  always_comb begin
    op    = start ? {1'b0, dividend} : {rem_r, 1'b0};
    d_sel = start ? divisor : d_r;
    diff  = {1'b0, op} - {2'b00, d_sel};
    ge    = ~diff[12];
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 4'd11;
      d_nxt    = divisor;
      rem_nxt  = ge ? diff[10:0] : op[10:0];
      q_nxt    = {11'd0, ge};
    end else if (busy_r) begin
      rem_nxt = ge ? diff[10:0] : op[10:0];
      q_nxt   = {q_r[10:0], ge};
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
    q_r   <= q_nxt;
  end

  assign done       = done_r;
  assign res.quot   = q_r;
  assign res.rem_nz = |rem_r;

  property p_done_ends_busy;
    @(posedge clk) disable iff (!rst_n) done_r |-> !busy_r;
  endproperty
  a_done_ends_busy: assert property (p_done_ends_busy)
    else $error("divider done while still busy");

  property p_start_busy;
    @(posedge clk) disable iff (!rst_n) start |=> busy_r && cnt_r == 4'd11;
  endproperty
  a_start_busy: assert property (p_start_busy)
    else $error("divider did not start");

  property p_quot_range;
    @(posedge clk) disable iff (!rst_n) done_r |-> q_r <= 12'd2048;
  endproperty
  a_quot_range: assert property (p_quot_range)
    else $error("quotient out of range");

endmodule

>>> hdl/sbus_frame_channel_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_channel_decoder: SBUS 25-byte frame to 16 channel results
// Collects frame bytes, checks head and tail, unpacks 11-bit channels and
// maps each to a linear, switch-level or raw result.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  in_      slave      tdata: rx_byte; tuser: frame_start
//  out_     master     tdata: channel_index, raw_value, mapped_value;
//                      tuser: mapping_kind; tlast: last
//  cfg_     slave      cfg_index, cfg_data register write
//
//  A byte is taken only in the idle state. After a good tail byte the block
//  sends 16 results: a linear channel passes through load (with the first
//  divider step), 11 more steps, done and send; any other channel, or a
//  linear one with an empty range, goes from load straight to send.
//  in_tready stays low until the last result is taken; an output stall
//  holds the current result. After reset the block waits for a frame_start
//  byte.
// ----------------------------------------------------------------------------
module sbus_frame_channel_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] rx_byte
  input  logic [0:0]                        in_tuser,   // [0] frame_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // [3:0] channel_index,
                                                        // [14:4] raw_value,
                                                        // [26:15] mapped_value
  output logic [1:0]                        out_tuser,  // [1:0] mapping_kind
  output logic                              out_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sbfcd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbfcd_pkg::RAW_W-1:0]       cfg_data
);

  localparam int RW = sbfcd_pkg::RAW_W;
  localparam int PB = sbfcd_pkg::PAYLOAD_BITS;

  sbfcd_pkg::seq_state_t state_r, state_nxt;

  logic [RW-1:0]                  min_r, max_r, mid_r;
  logic [sbfcd_pkg::TOL_W-1:0]    tol_r;
  logic [sbfcd_pkg::POS_W-1:0]    pos_r, pos_nxt, pos_eff;
  logic [7:0]                     head_r;
  logic [PB-1:0]                  data_r;
  logic [sbfcd_pkg::CH_W-1:0]     ch_r;
  logic                           half_r;

  logic [sbfcd_pkg::CH_W-1:0]     o_idx_r;
  logic [RW-1:0]                  o_raw_r;
  logic [sbfcd_pkg::MAP_W-1:0]    o_map_r;
  sbfcd_pkg::map_kind_t           o_kind_r;
  logic                           o_last_r;

  logic                           in_acc, out_acc, frame_ok;
  logic [RW-1:0]                  raw, xc, t;
  sbfcd_pkg::map_kind_t           kind;
  logic                           degen, need_div, half;
  logic signed [12:0]             xs, lo_th, hi_th, mid_lo, mid_hi;
  logic [sbfcd_pkg::MAP_W-1:0]    lvl_map, load_map, div_map;
  logic [12:0]                    div_sum;
  logic                           div_start, div_done;
  sbfcd_pkg::div_res_t            div_res;

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;

  // byte collection
  always_comb begin
    pos_eff  = in_tuser[0] ? '0 : pos_r;
    pos_nxt  = pos_r;
    frame_ok = 1'b0;
    if (in_acc && pos_eff < sbfcd_pkg::POS_W'(sbfcd_pkg::FRAME_BYTES)) begin
      pos_nxt = pos_eff + 1'b1;
      frame_ok = (pos_eff == sbfcd_pkg::POS_W'(sbfcd_pkg::FRAME_BYTES - 1))
                 && head_r == sbfcd_pkg::HEAD_BYTE
                 && in_tdata == sbfcd_pkg::TAIL_BYTE;
    end
  end

  // per-channel mapping of the channel at the bottom of the payload register
  always_comb begin
    raw    = data_r[RW-1:0];
    kind   = sbfcd_pkg::chan_kind(ch_r);
    degen  = max_r <= min_r;
    xc     = (raw < min_r) ? min_r : ((raw > max_r) ? max_r : raw);
    t      = xc - min_r;
    half   = {t, 1'b0} >= {1'b0, max_r - min_r};
    xs     = $signed({2'b00, raw});
    lo_th  = $signed({2'b00, min_r}) + $signed({3'b000, tol_r});
    hi_th  = $signed({2'b00, max_r}) - $signed({3'b000, tol_r});
    mid_lo = $signed({2'b00, mid_r}) - $signed({3'b000, tol_r});
    mid_hi = $signed({2'b00, mid_r}) + $signed({3'b000, tol_r});
    if (xs <= lo_th) begin
      lvl_map = 12'd1;
    end else if (xs >= hi_th) begin
      lvl_map = (kind == sbfcd_pkg::KIND_THREE) ? 12'd3 : 12'd2;
    end else if (kind == sbfcd_pkg::KIND_THREE && xs >= mid_lo && xs <= mid_hi) begin
      lvl_map = 12'd2;
    end else begin
      lvl_map = 12'd0;
    end
    case (kind) inside
      sbfcd_pkg::KIND_THREE, sbfcd_pkg::KIND_TWO: load_map = lvl_map;
      default:                                     load_map = '0;
    endcase
    need_div = kind == sbfcd_pkg::KIND_LINEAR && !degen;
    // truncate toward zero: below the midpoint round the quotient up
    div_sum  = {1'b0, div_res.quot} - 13'd1024
               + {12'd0, !half_r && div_res.rem_nz};
    div_map  = div_sum[sbfcd_pkg::MAP_W-1:0];
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sbfcd_pkg::ST_IDLE: if (frame_ok) state_nxt = sbfcd_pkg::ST_LOAD;
      sbfcd_pkg::ST_LOAD: state_nxt = need_div ? sbfcd_pkg::ST_DIV : sbfcd_pkg::ST_SEND;
      sbfcd_pkg::ST_DIV:  if (div_done) state_nxt = sbfcd_pkg::ST_SEND;
      sbfcd_pkg::ST_SEND: begin
        if (out_acc) begin
          state_nxt = o_last_r ? sbfcd_pkg::ST_IDLE : sbfcd_pkg::ST_LOAD;
        end
      end
      default: state_nxt = sbfcd_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    div_start  = 1'b0;
    unique case (state_r)
      sbfcd_pkg::ST_IDLE: in_tready  = 1'b1;
      sbfcd_pkg::ST_LOAD: div_start  = need_div;
      sbfcd_pkg::ST_DIV:  ;
      sbfcd_pkg::ST_SEND: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  sbfcd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (t),
    .divisor  (max_r - min_r),
    .done     (div_done),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sbfcd_pkg::ST_IDLE;
      pos_r   <= sbfcd_pkg::POS_W'(sbfcd_pkg::FRAME_BYTES);
      ch_r    <= '0;
      min_r   <= sbfcd_pkg::RANGE_MIN_RST;
      max_r   <= sbfcd_pkg::RANGE_MAX_RST;
      mid_r   <= sbfcd_pkg::MIDDLE_RST;
      tol_r   <= sbfcd_pkg::TOL_RST;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      if (state_r == sbfcd_pkg::ST_IDLE) begin
        ch_r <= '0;
      end else if (out_acc) begin
        ch_r <= ch_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sbfcd_pkg::CFG_RANGE_MIN: min_r <= cfg_data;
          sbfcd_pkg::CFG_RANGE_MAX: max_r <= cfg_data;
          sbfcd_pkg::CFG_MIDDLE:    mid_r <= cfg_data;
          sbfcd_pkg::CFG_TOLERANCE: tol_r <= cfg_data[sbfcd_pkg::TOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload: bytes 1..22 shift in from the top, channel 0 ends at the bottom
  always_ff @(posedge clk) begin
    if (in_acc && pos_eff < sbfcd_pkg::POS_W'(sbfcd_pkg::FRAME_BYTES)) begin
      if (pos_eff == '0) begin
        head_r <= in_tdata;
      end
      if (pos_eff != '0 && pos_eff <= sbfcd_pkg::POS_W'(sbfcd_pkg::LAST_PAYLOAD)) begin
        data_r <= {in_tdata, data_r[PB-1:8]};
      end
    end else if (out_acc) begin
      // advance to the next channel
      data_r <= {{RW{1'b0}}, data_r[PB-1:RW]};
    end
    if (state_r == sbfcd_pkg::ST_LOAD) begin
      o_idx_r  <= ch_r;
      o_raw_r  <= raw;
      o_kind_r <= kind;
      o_last_r <= ch_r == sbfcd_pkg::CH_W'(sbfcd_pkg::CHANNEL_COUNT - 1);
      o_map_r  <= load_map;
      half_r   <= half;
    end else if (state_r == sbfcd_pkg::ST_DIV && div_done) begin
      o_map_r  <= div_map;
    end
  end

  assign out_tdata = {5'd0, o_map_r, o_raw_r, o_idx_r};
  assign out_tuser = o_kind_r;
  assign out_tlast = o_last_r;

  property p_no_overlap;
    @(posedge clk) disable iff (!rst_n) out_tvalid |-> !in_tready;
  endproperty
  a_no_overlap: assert property (p_no_overlap)
    else $error("input taken while a result is pending");

  property p_last_index;
    @(posedge clk) disable iff (!rst_n) out_tvalid && out_tlast |-> out_tdata[3:0] == 4'hF;
  endproperty
  a_last_index: assert property (p_last_index)
    else $error("last flag on a channel other than the sixteenth");

  property p_continue;
    @(posedge clk) disable iff (!rst_n) out_acc && !out_tlast |=> !in_tready;
  endproperty
  a_continue: assert property (p_continue)
    else $error("frame results stopped before the last channel");

  property p_linear_range;
    @(posedge clk) disable iff (!rst_n)
      out_tvalid && out_tuser == sbfcd_pkg::KIND_LINEAR |->
        $signed(o_map_r) >= -12'sd1024 && $signed(o_map_r) <= 12'sd1024;
  endproperty
  a_linear_range: assert property (p_linear_range)
    else $error("linear value out of range");

endmodule
